### design/dtpg_pkg.sv
// shared types, constants and helper functions of the display test pattern generator
package dtpg_pkg;

   // coordinate and payload widths
   localparam int CoordW   = 16;
   localparam int PixelW   = 16;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;

   // divider pipeline depth: one quotient bit per stage
   localparam int DivSteps = 16;

   // cycles from an accepting edge to the edge that takes the result
   localparam int Latency  = DivSteps + 3;

   // configuration register indexes
   localparam logic [CsrIdxW-1:0] CSR_PATTERN_MODE = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_COLOR_INDEX  = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_STYLE        = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_FRAME_WIDTH  = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_FRAME_HEIGHT = 3'd4;

   // pattern modes
   typedef enum logic [2:0] {
      MODE_SOLID  = 3'd0,
      MODE_CHESS  = 3'd1,
      MODE_GRAD   = 3'd2,
      MODE_LINES  = 3'd3,
      MODE_MARKER = 3'd4
   } mode_type;

   // line pattern variants (style mod 3)
   localparam logic [1:0] LINE_CHECKER = 2'd0;
   localparam logic [1:0] LINE_PIXELS  = 2'd1;
   localparam logic [1:0] LINE_ROWS    = 2'd2;

   // per-item data that rides alongside the divider pipeline
   typedef struct packed {
      logic [CoordW-1:0] pos_x;
      logic [CoordW-1:0] pos_y;
      logic              grad_ovf;
   } side_type;

   // palette entry as red, green, blue full-scale flags (bit 2 red)
   function automatic logic [2:0] palette_mask(input logic [2:0] entry);
      logic [2:0] m;
      begin
         case (entry)
            3'd0:    m = 3'b111;  // white
            3'd1:    m = 3'b100;  // red
            3'd2:    m = 3'b110;  // yellow
            3'd3:    m = 3'b010;  // green
            3'd4:    m = 3'b011;  // cyan
            3'd5:    m = 3'b001;  // blue
            3'd6:    m = 3'b101;  // magenta
            default: m = 3'b000;
         endcase
         return m;
      end
   endfunction

   // rgb565 from an 8-bit level applied to the channels in the mask
   function automatic logic [PixelW-1:0] pack565(input logic [2:0] mask,
                                                 input logic [7:0] level);
      logic [4:0] r;
      logic [5:0] g;
      logic [4:0] b;
      begin
         r = mask[2] ? level[7:3] : 5'd0;
         g = mask[1] ? level[7:2] : 6'd0;
         b = mask[0] ? level[7:3] : 5'd0;
         return {r, g, b};
      end
   endfunction

   // color index mod 7 by reciprocal multiply
   function automatic logic [2:0] mod7(input logic [7:0] v);
      logic [16:0] prod;
      logic [5:0]  quo;
      logic [7:0]  rem;
      begin
         prod = 17'(v) * 17'd293;
         quo  = prod[16:11];
         rem  = v - (8'(quo) * 8'd7);
         return rem[2:0];
      end
   endfunction

   // style mod 3 by reciprocal multiply
   function automatic logic [1:0] mod3(input logic [7:0] v);
      logic [16:0] prod;
      logic [6:0]  quo;
      logic [7:0]  rem;
      begin
         prod = 17'(v) * 17'd171;
         quo  = prod[15:9];
         rem  = v - (8'(quo) * 8'd3);
         return rem[1:0];
      end
   endfunction

endpackage

### design/dtpg_div.sv
// pipelined restoring divider, one quotient bit per stage
module dtpg_div (
   input  logic        clock,
   input  logic [15:0] divisor,
   input  logic [15:0] rem_init,
   input  logic [15:0] dividend,
   output logic [15:0] quotient
);
   import dtpg_pkg::*;

   logic [15:0] rem_ff [DivSteps+1];
   logic [15:0] dvd_ff [DivSteps+1];
   logic [15:0] quo_ff [DivSteps+1];
   logic [15:0] rem_in [DivSteps+1];
   logic [15:0] dvd_in [DivSteps+1];
   logic [15:0] quo_in [DivSteps+1];
   logic [16:0] trial  [DivSteps];
   logic [16:0] diff   [DivSteps];
   logic        fits   [DivSteps];

   // one shift-subtract step between neighboring stages
   always_comb begin
      rem_in[0] = rem_init;
      dvd_in[0] = dividend;
      quo_in[0] = '0;
      for (int k = 0; k < DivSteps; k++) begin
         trial[k]    = {rem_ff[k], dvd_ff[k][15]};
         fits[k]     = trial[k] >= {1'b0, divisor};
         diff[k]     = trial[k] - {1'b0, divisor};
         rem_in[k+1] = fits[k] ? diff[k][15:0] : trial[k][15:0];
         dvd_in[k+1] = {dvd_ff[k][14:0], 1'b0};
         quo_in[k+1] = {quo_ff[k][14:0], fits[k]};
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      for (int k = 0; k <= DivSteps; k++) begin
         rem_ff[k] <= rem_in[k];
         dvd_ff[k] <= dvd_in[k];
         quo_ff[k] <= quo_in[k];
      end
   end

   assign quotient = quo_ff[DivSteps];

endmodule

### design/display_test_pattern_generator_core.sv
// top level of the display test pattern generator
//
// Usage: the pixel source raises start with req_pos_x / req_pos_y; a
// transaction is taken at every rising edge where start is high and busy
// is low. busy stays low, so one pixel coordinate can be taken per clock.
// Each transaction yields exactly one rsp_pixel_rgb565, shown for one
// cycle with rsp_valid high. Throughput is one pixel per cycle; latency is
// set by the 17 registers of the pipelined dividers behind the chessboard
// cell index and the gradient level, plus the input and output registers.
// Configuration goes through csr_write_en / csr_index / csr_write_data;
// derived settings sit in further registers. The user must see that it is
// only changed with no transaction in flight; the block does not enforce
// this. Synchronous reset empties the pipeline and restores solid mode,
// color index 0, style 0 and a 320 x 240 frame. The receiver cannot
// stall: results leave in order, one per accepted coordinate.
module display_test_pattern_generator_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [dtpg_pkg::CoordW-1:0]    req_pos_x,
   input  logic [dtpg_pkg::CoordW-1:0]    req_pos_y,
   output logic                           rsp_valid,
   output logic [dtpg_pkg::PixelW-1:0]    rsp_pixel_rgb565,
   input  logic                           csr_write_en,
   input  logic [dtpg_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [dtpg_pkg::CsrDataW-1:0]  csr_write_data
);
   import dtpg_pkg::*;

   // configuration registers
   logic [2:0]  mode_ff;
   logic [7:0]  color_ff;
   logic [7:0]  style_ff;
   logic [15:0] fw_ff;
   logic [15:0] fh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_SOLID;
         color_ff <= '0;
         style_ff <= '0;
         fw_ff    <= 16'd320;
         fh_ff    <= 16'd240;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_PATTERN_MODE: mode_ff  <= csr_write_data[2:0];
            CSR_COLOR_INDEX:  color_ff <= csr_write_data[7:0];
            CSR_STYLE:        style_ff <= csr_write_data[7:0];
            CSR_FRAME_WIDTH:  fw_ff    <= csr_write_data;
            CSR_FRAME_HEIGHT: fh_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   // derived settings, used only at the output stage
   logic [31:0] col_prod;
   logic [32:0] band_prod;
   logic [15:0] col_div_in, band_div_in;
   logic [15:0] col_div_ff, band_div_ff;
   logic [17:0] col_lim_in [4];
   logic [17:0] col_lim_ff [4];
   logic [18:0] band_lim_in [6];
   logic [18:0] band_lim_ff [6];
   logic [2:0]  mask_ff;
   logic [15:0] fg_ff;
   logic [1:0]  variant_ff;
   logic [2:0]  mask_in;

   always_comb begin
      col_prod    = 32'(fw_ff) * 32'd52429;
      band_prod   = 33'(fh_ff) * 33'd74899;
      col_div_in  = (col_prod[31:18] == '0) ? 16'd1 : {2'b0, col_prod[31:18]};
      band_div_in = (band_prod[32:19] == '0) ? 16'd1 : {2'b0, band_prod[32:19]};
      // column bounds d, 2d, 4d, 5d
      col_lim_in[0] = 18'(col_div_ff);
      col_lim_in[1] = 18'(col_div_ff) << 1;
      col_lim_in[2] = 18'(col_div_ff) << 2;
      col_lim_in[3] = (18'(col_div_ff) << 2) + 18'(col_div_ff);
      // band bounds d .. 6d
      for (int k = 0; k < 6; k++) begin
         band_lim_in[k] = 19'(band_div_ff) * 19'(k + 1);
      end
      mask_in = palette_mask(mod7(color_ff));
   end

   always_ff @(posedge clock) begin
      col_div_ff  <= col_div_in;
      band_div_ff <= band_div_in;
      col_lim_ff  <= col_lim_in;
      band_lim_ff <= band_lim_in;
      mask_ff     <= mask_in;
      fg_ff       <= pack565(mask_in, 8'hFF);
      variant_ff  <= mod3(style_ff);
   end

   // input stage
   logic        accept;
   logic        s1_valid_ff;
   logic [15:0] s1_x_ff, s1_y_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s1_x_ff <= req_pos_x;
      s1_y_ff <= req_pos_y;
   end

   // divider operands: chessboard cell and gradient level
   logic [15:0] cell_size;
   logic [15:0] tot;
   logic [23:0] grad_num;
   logic        grad_ovf;
   logic [15:0] qx, qy, qg;

   always_comb begin
      cell_size = (fw_ff[15:3] == '0) ? 16'd1 : {3'b0, fw_ff[15:3]};
      tot       = (fh_ff == '0) ? 16'd1 : fh_ff;
      grad_num  = {s1_y_ff, 8'b0} - 24'(s1_y_ff);
      grad_ovf  = grad_num >= {tot, 8'b0};
   end

   dtpg_div u_div_x (
      .clock    (clock),
      .divisor  (cell_size),
      .rem_init ('0),
      .dividend (s1_x_ff),
      .quotient (qx)
   );

   dtpg_div u_div_y (
      .clock    (clock),
      .divisor  (cell_size),
      .rem_init ('0),
      .dividend (s1_y_ff),
      .quotient (qy)
   );

   dtpg_div u_div_g (
      .clock    (clock),
      .divisor  (tot),
      .rem_init ({8'b0, grad_num[23:16]}),
      .dividend (grad_num[15:0]),
      .quotient (qg)
   );

   // valid bits and side data matched to the divider depth
   logic     sb_valid_ff [DivSteps+1];
   side_type sb_data_ff  [DivSteps+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DivSteps; k++) sb_valid_ff[k] <= 1'b0;
      end else begin
         sb_valid_ff[0] <= s1_valid_ff;
         for (int k = 1; k <= DivSteps; k++) sb_valid_ff[k] <= sb_valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      sb_data_ff[0] <= '{pos_x: s1_x_ff, pos_y: s1_y_ff, grad_ovf: grad_ovf};
      for (int k = 1; k <= DivSteps; k++) sb_data_ff[k] <= sb_data_ff[k-1];
   end

   // pixel selection
   side_type    side;
   logic        swap;
   logic [7:0]  level;
   logic        line_on;
   logic        col0, col1, col4;
   logic [5:0]  band_ge;
   logic        band_edge, band_bar;
   logic [15:0] front, back;
   logic [15:0] pixel_in;

   always_comb begin
      side = sb_data_ff[DivSteps];
      swap = style_ff[0];

      // gradient level, saturated
      if (swap) level = side.grad_ovf ? 8'd0 : 8'hFF - qg[7:0];
      else      level = side.grad_ovf ? 8'hFF : qg[7:0];

      // line variants
      case (variant_ff)
         LINE_PIXELS: line_on = (side.pos_y[0] & fw_ff[0]) ^ side.pos_x[0];
         LINE_ROWS:   line_on = side.pos_y[0];
         default:     line_on = !(side.pos_x[0] ^ side.pos_y[0]);
      endcase

      // marker column and band
      col0 = 18'(side.pos_x) < col_lim_ff[0];
      col1 = !col0 && (18'(side.pos_x) < col_lim_ff[1]);
      col4 = (18'(side.pos_x) >= col_lim_ff[2]) && (18'(side.pos_x) < col_lim_ff[3]);
      for (int k = 0; k < 6; k++) band_ge[k] = 19'(side.pos_y) >= band_lim_ff[k];
      band_edge = (band_ge[0] && !band_ge[1]) || (band_ge[2] && !band_ge[3]);
      band_bar  = (band_ge[1] && !band_ge[2]) || (band_ge[3] && !band_ge[5]);
      front = swap ? 16'd0 : fg_ff;
      back  = swap ? fg_ff : 16'd0;

      case (mode_ff)
         MODE_SOLID:  pixel_in = (color_ff[2:0] != 3'd0) ? fg_ff : 16'd0;
         MODE_CHESS:  pixel_in = ((qx[0] ^ qy[0]) != swap) ? fg_ff : 16'd0;
         MODE_GRAD:   pixel_in = pack565(mask_ff, level);
         MODE_LINES:  pixel_in = line_on ? fg_ff : 16'd0;
         MODE_MARKER: begin
            if (band_edge)     pixel_in = (col0 || col4) ? back : front;
            else if (band_bar) pixel_in = col1 ? front : back;
            else               pixel_in = back;
         end
         default:     pixel_in = 16'd0;
      endcase
   end

   // output register
   logic        rsp_valid_ff;
   logic [15:0] rsp_pixel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sb_valid_ff[DivSteps];
      end
   end

   always_ff @(posedge clock) begin
      rsp_pixel_ff <= pixel_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_rgb565 = rsp_pixel_ff;

endmodule

### design/dtpg_checker.sv
// port-level checker of the pattern generator and its bind
module dtpg_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic                           rsp_valid
);
   import dtpg_pkg::*;

   // the block never holds off a transaction
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // every accepted transaction yields a result after the fixed latency
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##Latency rsp_valid)
      else $error("result missing after accepted transaction");

   // no result appears without a transaction behind it
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, Latency))
      else $error("result without a transaction");

   // pipeline is empty right after reset
   a_reset_clears: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

endmodule

bind display_test_pattern_generator_core dtpg_checker u_dtpg_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid)
);
